/* sv/kli_pkg.sv */
// Shared types and constants of the keyframe linear interpolator.
`default_nettype none

package kli_pkg;

    localparam int MAX_KEYS   = 16;
    localparam int FRAME_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_KEYS);
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);
    localparam int VAL_W      = 32;
    localparam int LANES      = 3;
    localparam int DEN_W      = FRAME_BITS + 1;
    localparam int REM_W      = DEN_W + 1;
    localparam int MAG_W      = VAL_W + 1;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        REG_KEY_COUNT = 2'd0,
        REG_DEFAULT_X = 2'd1,
        REG_DEFAULT_Y = 2'd2,
        REG_DEFAULT_Z = 2'd3
    } t_reg_addr;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         key_index;
        logic [15:0]        key_frame;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [15:0]        frame;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [4:0]         segment;
    } t_out_item;

    typedef struct packed {
        logic [4:0]                  key_count;
        logic [LANES-1:0][VAL_W-1:0] dflt;
    } t_cfg;

    typedef struct packed {
        logic wr_key;
        logic load_eval;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic fin_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic div_last;
    } t_ctrl_stat;

endpackage

`default_nettype wire

/* sv/keyframe_linear_interpolator.sv */
// A key write item is stored in the key store as it is accepted. An evaluate item
// scans the key slots from slot 0 until a key frame at or past the frame is found
// or the clamped key count is reached, runs the 33-step quotient lanes when a key
// is found, and then loads the output register once the output slot is free.
// One item at a time: a new item is accepted only after the last one is done.
// Synchronous active-low reset clears the configuration registers and control; the key store
// holds no reset and must be written before it is evaluated.
`default_nettype none

module keyframe_linear_interpolator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire kli_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output kli_pkg::t_out_item              o_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kli_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kli_pkg::DATA_W-1:0] pwdata,
    output logic      [kli_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    kli_pkg::t_cfg       w_cfg;
    kli_pkg::t_ctrl_cmd  w_cmd;
    kli_pkg::t_ctrl_stat w_stat;

    kli_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    kli_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_item (i_in_data),
        .i_cfg  (w_cfg),
        .o_stat (w_stat),
        .o_item (o_out_data)
    );

endmodule

`default_nettype wire

/* sv/kli_regs.sv */
// APB register file: key count and default X, Y and Z values.
`default_nettype none

module kli_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kli_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kli_pkg::DATA_W-1:0] pwdata,
    output logic      [kli_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output kli_pkg::t_cfg                   o_cfg
);

    kli_pkg::t_reg_addr w_addr_sel;
    logic               w_wr;
    kli_pkg::t_cfg      r_cfg;

    assign w_addr_sel = kli_pkg::t_reg_addr'(paddr[3:2]);
    assign w_wr       = psel & penable & pwrite;
    assign pready     = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_addr_sel)
                kli_pkg::REG_KEY_COUNT: r_cfg.key_count <= pwdata[4:0];
                kli_pkg::REG_DEFAULT_X: r_cfg.dflt[0]   <= pwdata;
                kli_pkg::REG_DEFAULT_Y: r_cfg.dflt[1]   <= pwdata;
                kli_pkg::REG_DEFAULT_Z: r_cfg.dflt[2]   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_addr_sel)
            kli_pkg::REG_KEY_COUNT: prdata = {27'd0, r_cfg.key_count};
            kli_pkg::REG_DEFAULT_X: prdata = r_cfg.dflt[0];
            kli_pkg::REG_DEFAULT_Y: prdata = r_cfg.dflt[1];
            kli_pkg::REG_DEFAULT_Z: prdata = r_cfg.dflt[2];
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/kli_datapath.sv */
// Key store, scan registers and three bit-serial scaled-quotient lanes.
`default_nettype none

module kli_datapath (
    input  wire logic                i_clk,
    input  wire kli_pkg::t_ctrl_cmd  i_cmd,
    input  wire kli_pkg::t_in_item   i_item,
    input  wire kli_pkg::t_cfg       i_cfg,
    output kli_pkg::t_ctrl_stat      o_stat,
    output kli_pkg::t_out_item       o_item
);

    localparam int L = kli_pkg::LANES;

    logic [kli_pkg::FRAME_BITS-1:0]   r_frames [kli_pkg::MAX_KEYS];
    logic [L-1:0][kli_pkg::VAL_W-1:0] r_vals   [kli_pkg::MAX_KEYS];

    logic [kli_pkg::FRAME_BITS-1:0]   r_f;
    logic [kli_pkg::CNT_W-1:0]        r_idx;
    logic [kli_pkg::DEN_W-1:0]        r_oldp1;   // previous key frame plus one
    logic [L-1:0][kli_pkg::VAL_W-1:0] r_c;
    logic [kli_pkg::DEN_W-1:0]        r_num;
    logic [kli_pkg::DEN_W-1:0]        r_den;
    logic [kli_pkg::STEP_W-1:0]       r_step;
    logic [L-1:0][kli_pkg::MAG_W-1:0] r_mag;
    logic [L-1:0][kli_pkg::MAG_W-1:0] r_q;
    logic [L-1:0][kli_pkg::REM_W-1:0] r_r;
    logic [L-1:0]                     r_neg;
    kli_pkg::t_out_item               r_out;

    logic [kli_pkg::CNT_W-1:0]        w_cnt;
    logic [kli_pkg::FRAME_BITS-1:0]   w_k;
    logic [L-1:0][kli_pkg::VAL_W-1:0] w_v;
    logic [kli_pkg::DEN_W-1:0]        w_kp1;
    logic [kli_pkg::DEN_W-1:0]        w_fp1;
    logic [L-1:0][kli_pkg::MAG_W-1:0] w_diff;
    logic [L-1:0][kli_pkg::MAG_W-1:0] w_abs;
    logic [L-1:0][kli_pkg::MAG_W-1:0] n_q;
    logic [L-1:0][kli_pkg::REM_W-1:0] n_r;
    logic [L-1:0][kli_pkg::VAL_W-1:0] w_res;

    assign w_cnt = (i_cfg.key_count > 5'(kli_pkg::MAX_KEYS))
                 ? kli_pkg::CNT_W'(kli_pkg::MAX_KEYS)
                 : kli_pkg::CNT_W'(i_cfg.key_count);
    assign w_k   = r_frames[r_idx[kli_pkg::IDX_W-1:0]];
    assign w_v   = r_vals[r_idx[kli_pkg::IDX_W-1:0]];
    assign w_kp1 = {1'b0, w_k} + kli_pkg::DEN_W'(1);
    assign w_fp1 = {1'b0, r_f} + kli_pkg::DEN_W'(1);

    assign o_stat.scan_end = (r_idx >= w_cnt);
    assign o_stat.hit      = (w_k >= r_f);
    assign o_stat.div_last = (r_step == '0);
    assign o_item          = r_out;

    always_comb begin
        logic [kli_pkg::REM_W-1:0] t_r2;
        logic [kli_pkg::REM_W-1:0] t_r3;
        logic                      t_q1;
        logic                      t_q2;
        for (int l = 0; l < L; l++) begin
            w_diff[l] = {w_v[l][kli_pkg::VAL_W-1], w_v[l]}
                      - {r_c[l][kli_pkg::VAL_W-1], r_c[l]};
            w_abs[l]  = w_diff[l][kli_pkg::MAG_W-1] ? (~w_diff[l] + kli_pkg::MAG_W'(1))
                                                    : w_diff[l];
            // one bit of floor(mag * num / den): remainder stays below den
            t_r2 = {r_r[l][kli_pkg::REM_W-2:0], 1'b0};
            t_q1 = (t_r2 >= {1'b0, r_den});
            if (t_q1) begin
                t_r2 = t_r2 - {1'b0, r_den};
            end
            t_r3 = t_r2;
            t_q2 = 1'b0;
            if (r_mag[l][kli_pkg::MAG_W-1]) begin
                t_r3 = t_r2 + {1'b0, r_num};
                t_q2 = (t_r3 >= {1'b0, r_den});
                if (t_q2) begin
                    t_r3 = t_r3 - {1'b0, r_den};
                end
            end
            n_r[l] = t_r3;
            n_q[l] = {r_q[l][kli_pkg::MAG_W-2:0], 1'b0}
                   + kli_pkg::MAG_W'(t_q1) + kli_pkg::MAG_W'(t_q2);
            w_res[l] = r_neg[l] ? (r_c[l] - r_q[l][kli_pkg::VAL_W-1:0])
                                : (r_c[l] + r_q[l][kli_pkg::VAL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key) begin
            r_frames[i_item.key_index[kli_pkg::IDX_W-1:0]] <=
                i_item.key_frame[kli_pkg::FRAME_BITS-1:0];
            r_vals[i_item.key_index[kli_pkg::IDX_W-1:0]] <=
                {i_item.key_z, i_item.key_y, i_item.key_x};
        end

        if (i_cmd.load_eval) begin
            r_f     <= i_item.frame[kli_pkg::FRAME_BITS-1:0];
            r_idx   <= '0;
            r_oldp1 <= '0;
            r_c     <= i_cfg.dflt;
            r_q     <= '0;
            r_neg   <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx   <= r_idx + kli_pkg::CNT_W'(1);
            r_oldp1 <= w_kp1;
            r_c     <= w_v;
        end else if (i_cmd.div_start) begin
            r_num  <= w_fp1 - r_oldp1;
            r_den  <= w_kp1 - r_oldp1;
            r_step <= kli_pkg::STEP_W'(kli_pkg::MAG_W - 1);
            r_r    <= '0;
            r_q    <= '0;
            r_mag  <= w_abs;
            for (int l = 0; l < L; l++) begin
                r_neg[l] <= w_diff[l][kli_pkg::MAG_W-1];
            end
        end else if (i_cmd.div_step) begin
            r_step <= r_step - kli_pkg::STEP_W'(1);
            r_r    <= n_r;
            r_q    <= n_q;
            for (int l = 0; l < L; l++) begin
                r_mag[l] <= {r_mag[l][kli_pkg::MAG_W-2:0], 1'b0};
            end
        end

        if (i_cmd.fin_load) begin
            r_out.out_x   <= w_res[0];
            r_out.out_y   <= w_res[1];
            r_out.out_z   <= w_res[2];
            r_out.segment <= 5'(r_idx);
        end
    end

endmodule

`default_nettype wire

/* sv/kli_ctrl.sv */
// Controller: handshakes, scan and division sequencing.
`default_nettype none

module kli_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_cmd,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire kli_pkg::t_ctrl_stat i_stat,
    output kli_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_in_acc;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_cmd == kli_pkg::CMD_EVAL) begin
                        o_cmd.load_eval = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.wr_key = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_stat.scan_end) begin
                    n_state = S_FIN;
                end else if (i_stat.hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
